/* rtl/avp_pkg.sv */
// shared types, constants and angle table for the angular view projection block
package avp_pkg;

    localparam int CORDIC_STEPS_DEF = 20;
    localparam int CW  = 40;
    localparam int AW  = 26;
    localparam int CRD = 33;
    localparam int PW  = 32;
    localparam int FW  = 17;
    localparam int NDW = 20;
    localparam int CFG_AW = 3;

    localparam logic signed [AW-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [AW-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [AW+1:0] DEG360 = 28'sd23592960;
    localparam logic [27:0] INV_GAIN = 28'd163008219;

    localparam logic signed [NDW-1:0] NDC_MAX = 20'sd524287;
    localparam logic signed [NDW-1:0] NDC_MIN = -20'sd524288;

    localparam logic signed [PW-1:0] DIR_X_RST = 32'sd65536;
    localparam logic [FW-1:0] FOV_H_RST = 17'd23040;
    localparam logic [FW-1:0] FOV_V_RST = 17'd15360;

    typedef enum logic [CFG_AW-1:0] {
        REG_CAM_POS_X = 3'd0,
        REG_CAM_POS_Y = 3'd1,
        REG_CAM_POS_Z = 3'd2,
        REG_CAM_DIR_X = 3'd3,
        REG_CAM_DIR_Y = 3'd4,
        REG_CAM_DIR_Z = 3'd5,
        REG_FOV_HORIZ = 3'd6,
        REG_FOV_VERT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [PW-1:0] point_x;
        logic signed [PW-1:0] point_y;
        logic signed [PW-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [NDW-1:0] ndc_x;
        logic signed [NDW-1:0] ndc_y;
    } ndc_t;

    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/avp_cordic.sv */
// pipelined vectoring cordic: atan2 in degrees with axis cases, plus scaled length
module avp_cordic #(
    parameter int STEPS = avp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_vld,
    input  logic signed [avp_pkg::CW-1:0]    in_x,
    input  logic signed [avp_pkg::CW-1:0]    in_y,
    output logic                             out_vld,
    output logic signed [avp_pkg::AW-1:0]    angle,
    output logic signed [avp_pkg::CW-1:0]    mag
);

    logic [STEPS:0]                   vld_reg;
    logic signed [avp_pkg::CW-1:0]    x_reg [0:STEPS];
    logic signed [avp_pkg::CW-1:0]    y_reg [0:STEPS];
    logic signed [avp_pkg::AW-1:0]    z_reg [0:STEPS];
    logic [STEPS:0]                   spec_en_reg;
    logic signed [avp_pkg::AW-1:0]    spec_ang_reg [0:STEPS];
    logic signed [avp_pkg::AW-1:0]    off_reg [0:STEPS];

    logic                             spec_en_next;
    logic signed [avp_pkg::AW-1:0]    spec_ang_next;
    logic signed [avp_pkg::AW-1:0]    off_next;
    logic signed [avp_pkg::CW-1:0]    x_next;
    logic signed [avp_pkg::CW-1:0]    y_next;
    logic signed [avp_pkg::AW-1:0]    zsum;
    logic signed [avp_pkg::AW-1:0]    ang_next;

    logic                             out_vld_reg;
    logic signed [avp_pkg::AW-1:0]    angle_reg;
    logic signed [avp_pkg::CW-1:0]    mag_reg;

    // operand prep: fold left half plane, flag exact axes
    always_comb
    begin
        spec_en_next  = (in_y == 0) || (in_x == 0);
        if (in_y == 0)
        begin
            spec_ang_next = (in_x < 0) ? avp_pkg::DEG180 : '0;
        end
        else
        begin
            spec_ang_next = (in_y > 0) ? avp_pkg::DEG90 : -avp_pkg::DEG90;
        end
        if (in_x < 0)
        begin
            off_next = (in_y > 0) ? avp_pkg::DEG180 : -avp_pkg::DEG180;
            x_next   = -in_x;
            y_next   = -in_y;
        end
        else
        begin
            off_next = '0;
            x_next   = in_x;
            y_next   = in_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]        <= x_next;
        y_reg[0]        <= y_next;
        z_reg[0]        <= '0;
        spec_en_reg[0]  <= spec_en_next;
        spec_ang_reg[0] <= spec_ang_next;
        off_reg[0]      <= off_next;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + avp_pkg::atan_tab(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - avp_pkg::atan_tab(i);
            end
            spec_en_reg[i+1]  <= spec_en_reg[i];
            spec_ang_reg[i+1] <= spec_ang_reg[i];
            off_reg[i+1]      <= off_reg[i];
        end
    end

    // offset, clamp, axis override
    always_comb
    begin
        zsum = z_reg[STEPS] + off_reg[STEPS];
        if (spec_en_reg[STEPS])
        begin
            ang_next = spec_ang_reg[STEPS];
        end
        else if (zsum > avp_pkg::DEG180)
        begin
            ang_next = avp_pkg::DEG180;
        end
        else if (zsum < -avp_pkg::DEG180)
        begin
            ang_next = -avp_pkg::DEG180;
        end
        else
        begin
            ang_next = zsum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= ang_next;
        mag_reg   <= x_reg[STEPS];
    end

    assign out_vld = out_vld_reg;
    assign angle   = angle_reg;
    assign mag     = mag_reg;

endmodule

/* rtl/avp_lane.sv */
// one view lane: azimuth from x,y and elevation from z over the horizontal length
module avp_lane #(
    parameter int STEPS = avp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_vld,
    input  logic signed [avp_pkg::CRD-1:0]   in_x,
    input  logic signed [avp_pkg::CRD-1:0]   in_y,
    input  logic signed [avp_pkg::CRD-1:0]   in_z,
    output logic                             out_vld,
    output logic signed [avp_pkg::AW:0]      az,
    output logic signed [avp_pkg::AW-1:0]    el
);

    localparam int LAT = STEPS + 2;

    logic signed [avp_pkg::CW-1:0]   xw;
    logic signed [avp_pkg::CW-1:0]   yw;
    logic signed [avp_pkg::CW-1:0]   xa;
    logic signed [avp_pkg::CW-1:0]   ya;

    logic                            a_vld;
    logic signed [avp_pkg::AW-1:0]   a_ang;
    logic signed [avp_pkg::CW-1:0]   b_mag;

    logic signed [avp_pkg::CRD-1:0]  z_dly_reg [0:LAT-1];

    logic                            h1_vld_reg;
    logic                            h1_pos_reg;
    logic [45:0]                     pl_reg;
    logic [45:0]                     ph_reg;
    logic signed [avp_pkg::AW-1:0]   ang1_reg;
    logic signed [avp_pkg::CRD-1:0]  z1_reg;

    logic [63:0]                     prod;
    logic [64:0]                     prod_rnd;
    logic                            h2_vld_reg;
    logic [35:0]                     h2_reg;
    logic signed [avp_pkg::AW-1:0]   ang2_reg;
    logic signed [avp_pkg::CRD-1:0]  z2_reg;

    logic signed [avp_pkg::CW-1:0]   cx;
    logic signed [avp_pkg::CW-1:0]   cy;
    logic signed [avp_pkg::AW-1:0]   ang_dly_reg [0:LAT-1];

    always_comb
    begin
        xw = avp_pkg::CW'(in_x);
        yw = avp_pkg::CW'(in_y);
        xa = (xw < 0) ? -xw : xw;
        ya = (yw < 0) ? -yw : yw;
    end

    avp_cordic #(.STEPS(STEPS)) u_cordic_az (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld),
        .in_x    (xw),
        .in_y    (yw),
        .out_vld (a_vld),
        .angle   (a_ang),
        .mag     ()
    );

    avp_cordic #(.STEPS(STEPS)) u_cordic_len (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld),
        .in_x    (xa),
        .in_y    (ya),
        .out_vld (),
        .angle   (),
        .mag     (b_mag)
    );

    always_ff @(posedge clk)
    begin
        z_dly_reg[0] <= in_z;
        for (int k = 1; k < LAT; k++)
        begin
            z_dly_reg[k] <= z_dly_reg[k-1];
        end
    end

    // gain correction, split multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_vld_reg <= 1'b0;
            h2_vld_reg <= 1'b0;
        end
        else
        begin
            h1_vld_reg <= a_vld;
            h2_vld_reg <= h1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h1_pos_reg <= (b_mag > 0);
        pl_reg     <= b_mag[17:0] * avp_pkg::INV_GAIN;
        ph_reg     <= b_mag[35:18] * avp_pkg::INV_GAIN;
        ang1_reg   <= a_ang;
        z1_reg     <= z_dly_reg[LAT-1];
    end

    always_comb
    begin
        prod     = {18'd0, pl_reg} + {ph_reg, 18'd0};
        prod_rnd = {1'b0, prod} + 65'd134217728;
    end

    always_ff @(posedge clk)
    begin
        h2_reg   <= h1_pos_reg ? prod_rnd[63:28] : '0;
        ang2_reg <= ang1_reg;
        z2_reg   <= z1_reg;
    end

    always_comb
    begin
        cx = avp_pkg::CW'(signed'({1'b0, h2_reg}));
        cy = avp_pkg::CW'(z2_reg);
    end

    avp_cordic #(.STEPS(STEPS)) u_cordic_el (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (h2_vld_reg),
        .in_x    (cx),
        .in_y    (cy),
        .out_vld (out_vld),
        .angle   (el),
        .mag     ()
    );

    always_ff @(posedge clk)
    begin
        ang_dly_reg[0] <= ang2_reg;
        for (int k = 1; k < LAT; k++)
        begin
            ang_dly_reg[k] <= ang_dly_reg[k-1];
        end
    end

    assign az = (avp_pkg::AW+1)'(avp_pkg::DEG90) - (avp_pkg::AW+1)'(ang_dly_reg[LAT-1]);

endmodule

/* rtl/avp_ndc_div.sv */
// pipelined rounding divide of an angle times 256 by fov*500 with saturation
module avp_ndc_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_vld,
    input  logic signed [avp_pkg::AW-1:0]    ang,
    input  logic [avp_pkg::FW-1:0]           fov,
    output logic                             out_vld,
    output logic signed [avp_pkg::NDW-1:0]   ndc
);

    localparam int MW = avp_pkg::AW + 8;
    localparam int NN = MW;
    localparam int QB = NN - 8;
    localparam int DW = avp_pkg::FW + 9;

    logic                    neg_next;
    logic [avp_pkg::AW:0]    mag_next;
    logic [MW-1:0]           m_next;
    logic [DW-1:0]           den_next;
    logic [NN-1:0]           n_next;

    logic [QB:0]             vld_reg;
    logic [QB:0]             neg_reg;
    logic [QB:0]             nz_reg;
    logic [QB:0]             dz_reg;
    logic [DW-1:0]           rem_reg [0:QB];
    logic [NN-1:0]           n_reg [0:QB];
    logic [QB-1:0]           q_reg [0:QB];
    logic [DW-1:0]           den_reg [0:QB];

    logic [QB-1:0]           qf;
    logic signed [avp_pkg::NDW-1:0] ndc_next;
    logic                    out_vld_reg;
    logic signed [avp_pkg::NDW-1:0] ndc_reg;

    always_comb
    begin
        neg_next = (ang < 0);
        mag_next = neg_next ? -(avp_pkg::AW+1)'(ang) : (avp_pkg::AW+1)'(ang);
        m_next   = {mag_next[MW-9:0], 8'd0};
        den_next = DW'(fov) * DW'(9'd500);
        n_next   = m_next + NN'(den_next >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= neg_next;
        nz_reg[0]  <= (m_next != '0);
        dz_reg[0]  <= (den_next == '0);
        rem_reg[0] <= DW'(n_next[NN-1:QB]);
        n_reg[0]   <= n_next;
        q_reg[0]   <= '0;
        den_reg[0] <= den_next;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        logic [DW:0] t;
        logic        ge;
        logic [DW:0] diff;

        always_comb
        begin
            t    = {rem_reg[k], n_reg[k][QB-1-k]};
            ge   = (t >= {1'b0, den_reg[k]});
            diff = t - {1'b0, den_reg[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
            q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
            n_reg[k+1]   <= n_reg[k];
            den_reg[k+1] <= den_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            nz_reg[k+1]  <= nz_reg[k];
            dz_reg[k+1]  <= dz_reg[k];
        end
    end

    // sign and saturate
    always_comb
    begin
        qf = q_reg[QB];
        if (dz_reg[QB])
        begin
            if (!nz_reg[QB])
            begin
                ndc_next = '0;
            end
            else
            begin
                ndc_next = neg_reg[QB] ? avp_pkg::NDC_MIN : avp_pkg::NDC_MAX;
            end
        end
        else if (neg_reg[QB])
        begin
            if (qf >= QB'(524288))
            begin
                ndc_next = avp_pkg::NDC_MIN;
            end
            else
            begin
                ndc_next = -signed'(qf[avp_pkg::NDW-1:0]);
            end
        end
        else
        begin
            if (qf > QB'(524287))
            begin
                ndc_next = avp_pkg::NDC_MAX;
            end
            else
            begin
                ndc_next = signed'(qf[avp_pkg::NDW-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        ndc_reg <= ndc_next;
    end

    assign out_vld = out_vld_reg;
    assign ndc     = ndc_reg;

endmodule

/* rtl/angular_view_projection_top.sv */
// top level of the angular view projection block: config registers, lanes, dividers
// the path from start to done runs through two parallel cordic pipelines and a third
// chained behind them in each lane, then through the 26-stage ndc divider
// throughput one transaction per cycle, busy stays low, the receiver cannot stall
// async active-low reset clears valid bits and loads the camera register defaults
module angular_view_projection_top #(
    parameter int CORDIC_STEPS = avp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  avp_pkg::point_t               point,
    output logic                          done,
    output avp_pkg::ndc_t                 result,
    input  logic                          cfg_wr_en,
    input  logic [avp_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [avp_pkg::PW-1:0]        cfg_wdata
);

    logic signed [avp_pkg::PW-1:0]  pos_x_reg;
    logic signed [avp_pkg::PW-1:0]  pos_y_reg;
    logic signed [avp_pkg::PW-1:0]  pos_z_reg;
    logic signed [avp_pkg::PW-1:0]  dir_x_reg;
    logic signed [avp_pkg::PW-1:0]  dir_y_reg;
    logic signed [avp_pkg::PW-1:0]  dir_z_reg;
    logic [avp_pkg::FW-1:0]         fov_h_reg;
    logic [avp_pkg::FW-1:0]         fov_v_reg;

    logic                           in_vld_reg;
    logic signed [avp_pkg::CRD-1:0] rx_reg;
    logic signed [avp_pkg::CRD-1:0] ry_reg;
    logic signed [avp_pkg::CRD-1:0] rz_reg;

    logic                           pt_vld;
    logic signed [avp_pkg::AW:0]    pt_az;
    logic signed [avp_pkg::AW-1:0]  pt_el;
    logic signed [avp_pkg::AW:0]    cam_az;
    logic signed [avp_pkg::AW-1:0]  cam_el;

    logic signed [avp_pkg::AW+1:0]  az_sum;
    logic signed [avp_pkg::AW+1:0]  az_wrap;
    logic signed [avp_pkg::AW:0]    el_neg;

    logic                           cmb_vld_reg;
    logic signed [avp_pkg::AW-1:0]  az_reg;
    logic signed [avp_pkg::AW-1:0]  eln_reg;

    logic                           div_vld;
    logic signed [avp_pkg::NDW-1:0] ndc_x;
    logic signed [avp_pkg::NDW-1:0] ndc_y;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            dir_x_reg <= avp_pkg::DIR_X_RST;
            dir_y_reg <= '0;
            dir_z_reg <= '0;
            fov_h_reg <= avp_pkg::FOV_H_RST;
            fov_v_reg <= avp_pkg::FOV_V_RST;
        end
        else if (cfg_wr_en)
        begin
            case (avp_pkg::cfg_idx_t'(cfg_addr))
                avp_pkg::REG_CAM_POS_X: pos_x_reg <= cfg_wdata;
                avp_pkg::REG_CAM_POS_Y: pos_y_reg <= cfg_wdata;
                avp_pkg::REG_CAM_POS_Z: pos_z_reg <= cfg_wdata;
                avp_pkg::REG_CAM_DIR_X: dir_x_reg <= cfg_wdata;
                avp_pkg::REG_CAM_DIR_Y: dir_y_reg <= cfg_wdata;
                avp_pkg::REG_CAM_DIR_Z: dir_z_reg <= cfg_wdata;
                avp_pkg::REG_FOV_HORIZ: fov_h_reg <= cfg_wdata[avp_pkg::FW-1:0];
                avp_pkg::REG_FOV_VERT:  fov_v_reg <= cfg_wdata[avp_pkg::FW-1:0];
                default:                ;
            endcase
        end
    end

    // point relative to camera
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= avp_pkg::CRD'(point.point_x) - avp_pkg::CRD'(pos_x_reg);
        ry_reg <= avp_pkg::CRD'(point.point_y) - avp_pkg::CRD'(pos_y_reg);
        rz_reg <= avp_pkg::CRD'(point.point_z) - avp_pkg::CRD'(pos_z_reg);
    end

    avp_lane #(.STEPS(CORDIC_STEPS)) u_lane_pt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld_reg),
        .in_x    (rx_reg),
        .in_y    (ry_reg),
        .in_z    (rz_reg),
        .out_vld (pt_vld),
        .az      (pt_az),
        .el      (pt_el)
    );

    avp_lane #(.STEPS(CORDIC_STEPS)) u_lane_cam (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld_reg),
        .in_x    (avp_pkg::CRD'(dir_x_reg)),
        .in_y    (avp_pkg::CRD'(dir_y_reg)),
        .in_z    (avp_pkg::CRD'(dir_z_reg)),
        .out_vld (),
        .az      (cam_az),
        .el      (cam_el)
    );

    // azimuth sum with one wrap, negated elevation
    always_comb
    begin
        az_sum = (avp_pkg::AW+2)'(cam_az) + (avp_pkg::AW+2)'(pt_az);
        if (az_sum > (avp_pkg::AW+2)'(avp_pkg::DEG180))
        begin
            az_wrap = az_sum - avp_pkg::DEG360;
        end
        else if (az_sum < -(avp_pkg::AW+2)'(avp_pkg::DEG180))
        begin
            az_wrap = az_sum + avp_pkg::DEG360;
        end
        else
        begin
            az_wrap = az_sum;
        end
        el_neg = (avp_pkg::AW+1)'(pt_el) - (avp_pkg::AW+1)'(cam_el);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmb_vld_reg <= 1'b0;
        end
        else
        begin
            cmb_vld_reg <= pt_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        az_reg  <= az_wrap[avp_pkg::AW-1:0];
        eln_reg <= el_neg[avp_pkg::AW-1:0];
    end

    avp_ndc_div u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (cmb_vld_reg),
        .ang     (az_reg),
        .fov     (fov_h_reg),
        .out_vld (div_vld),
        .ndc     (ndc_x)
    );

    avp_ndc_div u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (cmb_vld_reg),
        .ang     (eln_reg),
        .fov     (fov_v_reg),
        .out_vld (),
        .ndc     (ndc_y)
    );

    assign done         = div_vld;
    assign result.ndc_x = ndc_x;
    assign result.ndc_y = ndc_y;

endmodule

/* tb/sv/tb_angular_view_projection_top.sv */
// testbench for the angular view projection block: scoreboard, stimulus and checks
module tb_angular_view_projection_top;

    timeunit 1ns;
    timeprecision 1ps;

    class projection_scoreboard;
        int                         cam_pos [3];
        int                         cam_dir [3];
        logic [avp_pkg::FW-1:0]     fov_h;
        logic [avp_pkg::FW-1:0]     fov_v;
        avp_pkg::ndc_t              ndc_queue [$];
        int                         mismatches;
        int                         failures;
        longint                     deg_tab [32];

        function new();
            deg_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
            cam_pos = '{0, 0, 0};
            cam_dir = '{65536, 0, 0};
            fov_h = 17'd23040;
            fov_v = 17'd15360;
            mismatches = 0;
            failures = 0;
        endfunction

        function void write_reg(avp_pkg::cfg_idx_t idx, logic [31:0] v);
            case (idx)
                avp_pkg::REG_CAM_POS_X: cam_pos[0] = v;
                avp_pkg::REG_CAM_POS_Y: cam_pos[1] = v;
                avp_pkg::REG_CAM_POS_Z: cam_pos[2] = v;
                avp_pkg::REG_CAM_DIR_X: cam_dir[0] = v;
                avp_pkg::REG_CAM_DIR_Y: cam_dir[1] = v;
                avp_pkg::REG_CAM_DIR_Z: cam_dir[2] = v;
                avp_pkg::REG_FOV_HORIZ: fov_h = v[avp_pkg::FW-1:0];
                avp_pkg::REG_FOV_VERT:  fov_v = v[avp_pkg::FW-1:0];
                default: ;
            endcase
        endfunction

        function void rotate_vector(inout longint xv, inout longint yv, output longint z);
            longint xs, ys;
            z = 0;
            for (int i = 0; i < avp_pkg::CORDIC_STEPS_DEF && i < 32; i++) begin
                xs = xv >>> i;
                ys = yv >>> i;
                if (yv > 0) begin
                    xv += ys; yv -= xs; z += deg_tab[i];
                end
                else begin
                    xv -= ys; yv += xs; z -= deg_tab[i];
                end
            end
        endfunction

        function longint angle_of(longint y, longint x);
            longint off, z;
            off = 0;
            if (y == 0)
                return (x < 0) ? 64'sd11796480 : 64'sd0;
            if (x == 0)
                return (y > 0) ? 64'sd5898240 : -64'sd5898240;
            if (x < 0) begin
                off = (y > 0) ? 64'sd11796480 : -64'sd11796480;
                x = -x;
                y = -y;
            end
            rotate_vector(x, y, z);
            z += off;
            if (z > 64'sd11796480) z = 64'sd11796480;
            if (z < -64'sd11796480) z = -64'sd11796480;
            return z;
        endfunction

        function longint planar_length(longint a, longint b);
            longint x, y, z;
            x = (a < 0) ? -a : a;
            y = (b < 0) ? -b : b;
            rotate_vector(x, y, z);
            if (x <= 0)
                return 0;
            return (x * 64'sd163008219 + (64'sd1 <<< 27)) >>> 28;
        endfunction

        function logic signed [avp_pkg::NDW-1:0] screen_coord(longint ang,
                                                              logic [avp_pkg::FW-1:0] fov);
            longint num, den, m, q, r;
            num = ang * 256;
            den = longint'(fov) * 500;
            if (den == 0)
                r = (num > 0) ? 524287 : (num < 0) ? -524288 : 0;
            else begin
                m = (num < 0) ? -num : num;
                q = (m + den / 2) / den;
                if (q > (64'sd1 <<< 20)) q = 64'sd1 <<< 20;
                r = (num < 0) ? -q : q;
                if (r > 524287) r = 524287;
                if (r < -524288) r = -524288;
            end
            return r[avp_pkg::NDW-1:0];
        endfunction

        function void note_point(avp_pkg::point_t p);
            longint dx, dy, dz, rx, ry, rz, az, el;
            avp_pkg::ndc_t e;
            dx = cam_dir[0];
            dy = cam_dir[1];
            dz = cam_dir[2];
            rx = longint'(p.point_x) - longint'(cam_pos[0]);
            ry = longint'(p.point_y) - longint'(cam_pos[1]);
            rz = longint'(p.point_z) - longint'(cam_pos[2]);
            az = (64'sd5898240 - angle_of(dy, dx)) + (64'sd5898240 - angle_of(ry, rx));
            el = angle_of(dz, planar_length(dx, dy)) - angle_of(rz, planar_length(rx, ry));
            if (az > 64'sd11796480) az -= 64'sd23592960;
            if (az < -64'sd11796480) az += 64'sd23592960;
            e.ndc_x = screen_coord(az, fov_h);
            e.ndc_y = screen_coord(-el, fov_v);
            ndc_queue.insert(ndc_queue.size(), e);
        endfunction

        function void check_result(avp_pkg::ndc_t got);
            avp_pkg::ndc_t e;
            if (ndc_queue.size() == 0) begin
                failures++;
                if (failures + mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d", got.ndc_x, got.ndc_y);
                return;
            end
            e = ndc_queue.pop_front();
            if (got.ndc_x !== e.ndc_x || got.ndc_y !== e.ndc_y) begin
                mismatches++;
                if (mismatches + failures <= 10)
                    $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                             e.ndc_x, e.ndc_y, got.ndc_x, got.ndc_y);
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    avp_pkg::point_t                point;
    logic                           done;
    avp_pkg::ndc_t                  result;
    logic                           cfg_wr_en;
    logic [avp_pkg::CFG_AW-1:0]     cfg_addr;
    logic [avp_pkg::PW-1:0]         cfg_wdata;

    projection_scoreboard  sb;
    int                    accepted;

    angular_view_projection_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.write_reg(avp_pkg::cfg_idx_t'(cfg_addr), cfg_wdata);
            if (start && !busy)
            begin
                sb.note_point(point);
                accepted++;
            end
            if (done)
                sb.check_result(result);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // caller stands at a falling edge and returns at one
    task automatic send_point(avp_pkg::point_t p, int gap);
        int n;
        start <= 1'b1;
        point <= p;
        n = accepted;
        while (accepted == n)
            @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.ndc_queue.size() != 0)
            @(negedge clk);
        repeat (2 * avp_pkg::CORDIC_STEPS_DEF + 44) @(negedge clk);
    endtask

    task automatic write_reg(avp_pkg::cfg_idx_t idx, logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(negedge clk);
    endtask

    task automatic set_camera(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                              logic [31:0] fh, logic [31:0] fv);
        write_reg(avp_pkg::REG_CAM_POS_X, px);
        write_reg(avp_pkg::REG_CAM_POS_Y, py);
        write_reg(avp_pkg::REG_CAM_POS_Z, pz);
        write_reg(avp_pkg::REG_CAM_DIR_X, dx);
        write_reg(avp_pkg::REG_CAM_DIR_Y, dy);
        write_reg(avp_pkg::REG_CAM_DIR_Z, dz);
        write_reg(avp_pkg::REG_FOV_HORIZ, fh);
        write_reg(avp_pkg::REG_FOV_VERT, fv);
        cfg_wr_en <= 1'b0;
        cfg_wdata <= $urandom;
    endtask

    function automatic logic [31:0] near_value(int base);
        case ($urandom_range(0, 3))
            0: return base;
            1: return base + $signed($urandom_range(0, 8191)) - 4096;
            2: return base + $signed($urandom_range(0, 33554431)) - 16777216;
            default: return $urandom;
        endcase
    endfunction

    function automatic avp_pkg::point_t rand_point();
        avp_pkg::point_t p;
        if ($urandom_range(0, 3) == 0)
        begin
            p.point_x = $urandom;
            p.point_y = $urandom;
            p.point_z = $urandom;
        end
        else
        begin
            p.point_x = near_value(sb.cam_pos[0]);
            p.point_y = near_value(sb.cam_pos[1]);
            p.point_z = near_value(sb.cam_pos[2]);
        end
        return p;
    endfunction

    task automatic directed_points();
        int c [3];
        int big [6];
        avp_pkg::point_t p;
        c = sb.cam_pos;
        big = '{32'h7fffffff, 32'h80000000, 1, -1, 65536, -65536};
        send_point('{c[0], c[1], c[2]}, 0);
        for (int i = 0; i < 6; i++)
        begin
            send_point('{c[0] + big[i], c[1], c[2]}, 0);
            send_point('{c[0], c[1] + big[i], c[2]}, pick_gap());
            send_point('{c[0], c[1], c[2] + big[i]}, 0);
        end
        send_point('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1);
        send_point('{32'h80000000, 32'h80000000, 32'h80000000}, 0);
        send_point('{32'h7fffffff, 32'h80000000, 32'h7fffffff}, 0);
        send_point('{32'hffffffff, 32'h00000000, 32'h80000000}, 2);
    endtask

    task automatic random_points(int n);
        for (int i = 0; i < n; i++)
            send_point(rand_point(), pick_gap());
    endtask

    initial
    begin
        #2_000_000;
        $display("[angular_view_projection_top] ERROR");
        $finish;
    end

    initial
    begin
        sb = new();
        accepted = 0;
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_points();
        random_points(100);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h80000000, 32'h7fffffff, 256, 92160);
                1: set_camera(32'h80000000, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h80000000, 92160, 256);
                2: set_camera(0, 0, 0, 0, 0, 0, 0, 0);
                3: set_camera(65536, -65536, 0, -65536, 0, 0, 1, 17'h1ffff);
                4: set_camera(0, 0, 0, 0, -65536, 65536, 17'h1ffff, 1);
                default: set_camera($urandom, $urandom, $urandom, near_value(0),
                                    near_value(0), near_value(0),
                                    $urandom_range(256, 92160), $urandom_range(256, 92160));
            endcase
            @(negedge clk);
            if (ph < 2)
                directed_points();
            random_points(90);
            drain();
        end

        if (sb.mismatches == 0 && sb.failures == 0)
            $display("[angular_view_projection_top] OK");
        else
            $display("[angular_view_projection_top] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/avp_pkg.sv
rtl/avp_cordic.sv
rtl/avp_lane.sv
rtl/avp_ndc_div.sv
rtl/angular_view_projection_top.sv
tb/sv/tb_angular_view_projection_top.sv
